// ===== rtl/fmt_pkg.sv =====
// ----------------------------------------------------------------------------
// fmt_pkg
// Types and constants shared by the flow match table cells and core.
// ----------------------------------------------------------------------------
package fmt_pkg;

  localparam int DEF_TABLE_ENTRIES = 64;

  localparam int SW_W   = 8;
  localparam int MAC_W  = 48;
  localparam int PORT_W = 16;

  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_LOOKUP = 2'd1;
  localparam logic [1:0] REQ_REMOVE = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_PRESENT   = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  typedef struct packed {
    logic [SW_W-1:0]   sw;
    logic [MAC_W-1:0]  dst;
    logic [MAC_W-1:0]  src;
    logic [PORT_W-1:0] port;
  } entry_t;

  typedef struct packed {
    logic match;
    logic select;
    logic any_hit;
    logic ins_en;
    logic rem_en;
  } cell_ctrl_t;

endpackage

// ===== rtl/fmt_cell.sv =====
// ----------------------------------------------------------------------------
// fmt_cell
// One table slot: holds an entry, compares it against the request, and takes
// its younger neighbor's entry when a removal at or below it compacts the row.
// ----------------------------------------------------------------------------
module fmt_cell import fmt_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  cell_ctrl_t ctrl,
  input  logic [1:0] req_op,
  input  entry_t     req,
  input  logic       prev_valid,
  input  logic       next_valid,
  input  entry_t     next_entry,
  input  logic       younger,
  output logic       valid,
  output entry_t     entry,
  output logic       hit,
  output logic       sel,
  output entry_t     sel_entry
);

  logic key_eq;
  logic port_eq;
  logic hit_next;
  logic shift;
  logic do_ins;
  logic do_rem;

  assign key_eq  = valid && (entry.sw == req.sw) && (entry.dst == req.dst)
                   && (entry.src == req.src);
  assign port_eq = valid && (entry.sw == req.sw) && (entry.port == req.port);

  always_comb begin
    case (req_op)
      REQ_INSERT: hit_next = key_eq;
      REQ_LOOKUP: hit_next = key_eq;
      REQ_REMOVE: hit_next = port_eq;
      default:    hit_next = 1'b0;
    endcase
  end

  assign do_ins = ctrl.ins_en && !valid && prev_valid;
  assign do_rem = ctrl.rem_en && shift;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      hit   <= 1'b0;
      sel   <= 1'b0;
      shift <= 1'b0;
    end else begin
      if (ctrl.match) begin
        hit <= hit_next;
      end
      if (ctrl.select) begin
        sel   <= hit && !younger;
        shift <= ctrl.any_hit && !younger;
      end
      if (do_ins) begin
        valid <= 1'b1;
      end else if (do_rem) begin
        valid <= next_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_ins) begin
      entry <= req;
    end else if (do_rem) begin
      entry <= next_entry;
    end
  end

  assign sel_entry = sel ? entry : '0;

endmodule

// ===== rtl/flow_match_table_core.sv =====
// ----------------------------------------------------------------------------
// flow_match_table_core
// Exact-match flow table kept compacted and ordered by age in a row of cells.
// Each request steps through match, newest-hit select and resolve; a new
// request is accepted only in idle, after the previous one has resolved.
// Resolve waits while the output register still holds an untaken result.
// Reset clears all valid bits at once; no clearing sweep is needed.
// ----------------------------------------------------------------------------
module flow_match_table_core import fmt_pkg::*; #(
  parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        req_type,
  input  logic [SW_W-1:0]   switch_id,
  input  logic [MAC_W-1:0]  dst_mac,
  input  logic [MAC_W-1:0]  src_mac,
  input  logic [PORT_W-1:0] egress_port,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        status,
  output logic [PORT_W-1:0] found_port,
  output logic [MAC_W-1:0]  found_dst_mac,
  output logic [MAC_W-1:0]  found_src_mac
);

  localparam int STEPS = $clog2(TABLE_ENTRIES);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_MATCH = 4'b0010,
    S_SEL   = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  state_t     state;
  state_t     state_next;
  logic [1:0] req_op;
  entry_t     req;
  logic       any_hit_r;
  logic       full_r;
  logic       can_load;
  cell_ctrl_t ctrl;

  logic [TABLE_ENTRIES-1:0] valid_vec;
  logic [TABLE_ENTRIES-1:0] hit_vec;
  logic [TABLE_ENTRIES-1:0] sel_vec;
  logic [TABLE_ENTRIES-1:0] younger_vec;
  logic [TABLE_ENTRIES-1:0] prev_valid_vec;
  logic [TABLE_ENTRIES-1:0] next_valid_vec;
  entry_t                   entry_vec      [TABLE_ENTRIES];
  entry_t                   next_entry_vec [TABLE_ENTRIES];
  entry_t                   sel_entry_vec  [TABLE_ENTRIES];
  entry_t                   found;

  assign in_ready = (state == S_IDLE);
  assign can_load = !out_valid || out_ready;

  always_comb begin
    case (state)
      S_IDLE:  state_next = (in_valid) ? S_MATCH : S_IDLE;
      S_MATCH: state_next = S_SEL;
      S_SEL:   state_next = S_DONE;
      S_DONE:  state_next = (can_load) ? S_IDLE : S_DONE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_op   <= req_type;
      req.sw   <= switch_id;
      req.dst  <= dst_mac;
      req.src  <= src_mac;
      req.port <= egress_port;
    end
    if (state == S_SEL) begin
      any_hit_r <= |hit_vec;
      full_r    <= valid_vec[TABLE_ENTRIES-1];
    end
  end

  // suffix OR: younger_vec[i] set when any slot above i hits
  always_comb begin
    younger_vec = hit_vec >> 1;
    for (int k = 0; k < STEPS; k++) begin
      younger_vec = younger_vec | (younger_vec >> (1 << k));
    end
  end

  always_comb begin
    ctrl.match   = (state == S_MATCH);
    ctrl.select  = (state == S_SEL);
    ctrl.any_hit = |hit_vec;
    ctrl.ins_en  = (state == S_DONE) && can_load && (req_op == REQ_INSERT)
                   && !any_hit_r && !full_r;
    ctrl.rem_en  = (state == S_DONE) && can_load && (req_op == REQ_REMOVE)
                   && any_hit_r;
  end

  genvar gi;
  generate
    for (gi = 0; gi < TABLE_ENTRIES; gi++) begin : g_cell
      if (gi == 0) begin : g_first
        assign prev_valid_vec[gi] = 1'b1;
      end else begin : g_mid
        assign prev_valid_vec[gi] = valid_vec[gi-1];
      end
      if (gi == TABLE_ENTRIES - 1) begin : g_last
        assign next_valid_vec[gi] = 1'b0;
        assign next_entry_vec[gi] = '0;
      end else begin : g_inner
        assign next_valid_vec[gi] = valid_vec[gi+1];
        assign next_entry_vec[gi] = entry_vec[gi+1];
      end

      fmt_cell u_cell (
        .clk        (clk),
        .rst        (rst),
        .ctrl       (ctrl),
        .req_op     (req_op),
        .req        (req),
        .prev_valid (prev_valid_vec[gi]),
        .next_valid (next_valid_vec[gi]),
        .next_entry (next_entry_vec[gi]),
        .younger    (younger_vec[gi]),
        .valid      (valid_vec[gi]),
        .entry      (entry_vec[gi]),
        .hit        (hit_vec[gi]),
        .sel        (sel_vec[gi]),
        .sel_entry  (sel_entry_vec[gi])
      );
    end
  endgenerate

  always_comb begin
    found = '0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      found = found | sel_entry_vec[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && can_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && can_load) begin
      found_port    <= '0;
      found_dst_mac <= '0;
      found_src_mac <= '0;
      case (req_op)
        REQ_INSERT: begin
          status <= any_hit_r ? ST_PRESENT : (full_r ? ST_FULL : ST_OK);
        end
        REQ_LOOKUP, REQ_REMOVE: begin
          status <= any_hit_r ? ST_OK : ST_NOT_FOUND;
          if (any_hit_r) begin
            found_port    <= found.port;
            found_dst_mac <= found.dst;
            found_src_mac <= found.src;
          end
        end
        default: begin
          status <= ST_NOT_FOUND;
        end
      endcase
    end
  end

  a_compact: assert property (@(posedge clk) disable iff (rst)
    (valid_vec & (valid_vec + 1'b1)) == '0)
    else $error("valid slots not compacted");

  a_single_sel: assert property (@(posedge clk) disable iff (rst)
    state == S_DONE |-> $onehot0(sel_vec))
    else $error("more than one slot selected");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    ctrl.ins_en |=> $countones(valid_vec) == $past($countones(valid_vec)) + 1)
    else $error("insert did not add one entry");

  a_remove_shrinks: assert property (@(posedge clk) disable iff (rst)
    ctrl.rem_en |=> $countones(valid_vec) + 1 == $past($countones(valid_vec)))
    else $error("remove did not drop one entry");

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> state == S_MATCH && !out_valid || state == S_MATCH)
    else $error("transfer did not start a match");

endmodule

// ===== sim/flow_match_table_tb.sv =====
// ----------------------------------------------------------------------------
// flow_match_table_core testbench
// Drives insert, lookup and remove requests and checks every result against
// the expected values of its directed row or a local model of the age-ordered,
// compacted table. Directed rows cover the empty table, field extremes,
// duplicates and newest-first removal. Random phases then mix, fill past
// capacity and drain the table, with random idle bursts on both channels.
// ----------------------------------------------------------------------------
module testbench;
  import fmt_pkg::*;

  localparam int                TABLE_ENTRIES = DEF_TABLE_ENTRIES;
  localparam logic [1:0]        REQ_UNUSED    = 2'd3;
  localparam int                IDLE_LIMIT    = 2000;
  localparam int                PHASES        = 8;
  localparam logic [MAC_W-1:0]  MAC_ONES      = '1;
  localparam logic [PORT_W-1:0] PORT_ONES     = '1;

  typedef enum int {MODE_MIX, MODE_FILL, MODE_DRAIN} traffic_mode_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [PORT_W-1:0] port;
    logic [MAC_W-1:0]  dst;
    logic [MAC_W-1:0]  src;
  } flow_result_t;

  typedef struct {
    logic [1:0]        req;
    logic [SW_W-1:0]   sw;
    logic [MAC_W-1:0]  dst;
    logic [MAC_W-1:0]  src;
    logic [PORT_W-1:0] port;
    bit                typed;
    flow_result_t      want;
  } flow_req_t;

  logic              clk;
  logic              rst;
  logic              in_valid;
  logic              in_ready;
  logic [1:0]        req_type;
  logic [SW_W-1:0]   switch_id;
  logic [MAC_W-1:0]  dst_mac;
  logic [MAC_W-1:0]  src_mac;
  logic [PORT_W-1:0] egress_port;
  logic              out_valid;
  logic              out_ready;
  logic [1:0]        status;
  logic [PORT_W-1:0] found_port;
  logic [MAC_W-1:0]  found_dst_mac;
  logic [MAC_W-1:0]  found_src_mac;

  bit           cur_typed;
  flow_result_t cur_want;
  bit           stall_on;

  entry_t       flow_tbl [TABLE_ENTRIES];
  int           flow_count;
  int           peak_count;
  flow_result_t pending_results [$];

  int errors;
  int n_results;
  int n_req [4];
  int n_status [4];
  int idle_cycles;

  flow_req_t    seen_req;
  flow_result_t predicted;
  flow_result_t oldest;

  flow_match_table_core #(.TABLE_ENTRIES(TABLE_ENTRIES)) dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .req_type      (req_type),
    .switch_id     (switch_id),
    .dst_mac       (dst_mac),
    .src_mac       (src_mac),
    .egress_port   (egress_port),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .status        (status),
    .found_port    (found_port),
    .found_dst_mac (found_dst_mac),
    .found_src_mac (found_src_mac)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  function automatic logic [MAC_W-1:0] rand_mac();
    logic [63:0] w;
    w = {$urandom(), $urandom()};
    return w[MAC_W-1:0];
  endfunction

  function automatic int find_flow(flow_req_t rq);
    int i;
    for (i = 0; i < flow_count; i++) begin
      if (flow_tbl[i].sw == rq.sw && flow_tbl[i].dst == rq.dst && flow_tbl[i].src == rq.src) begin
        return i;
      end
    end
    return -1;
  endfunction

  function automatic flow_result_t apply_request(flow_req_t rq);
    flow_result_t res;
    int hit;
    int i;
    res = '{ST_NOT_FOUND, '0, '0, '0};
    hit = -1;
    case (rq.req)
      REQ_INSERT: begin
        if (find_flow(rq) >= 0) begin
          res.status = ST_PRESENT;
        end else if (flow_count >= TABLE_ENTRIES) begin
          res.status = ST_FULL;
        end else begin
          flow_tbl[flow_count] = '{rq.sw, rq.dst, rq.src, rq.port};
          flow_count++;
          res.status = ST_OK;
        end
      end
      REQ_LOOKUP: begin
        hit = find_flow(rq);
        if (hit >= 0) begin
          res = '{ST_OK, flow_tbl[hit].port, flow_tbl[hit].dst, flow_tbl[hit].src};
        end
      end
      REQ_REMOVE: begin
        for (i = flow_count - 1; i >= 0 && hit < 0; i--) begin
          if (flow_tbl[i].sw == rq.sw && flow_tbl[i].port == rq.port) hit = i;
        end
        if (hit >= 0) begin
          res = '{ST_OK, flow_tbl[hit].port, flow_tbl[hit].dst, flow_tbl[hit].src};
          for (i = hit; i < flow_count - 1; i++) flow_tbl[i] = flow_tbl[i + 1];
          flow_count--;
        end
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  function automatic flow_req_t stim_row(logic [1:0] req, logic [SW_W-1:0] sw,
                                         logic [MAC_W-1:0] dst, logic [MAC_W-1:0] src,
                                         logic [PORT_W-1:0] port, bit typed,
                                         logic [1:0] st, logic [PORT_W-1:0] fport,
                                         logic [MAC_W-1:0] fdst, logic [MAC_W-1:0] fsrc);
    flow_req_t rq;
    rq.req   = req;
    rq.sw    = sw;
    rq.dst   = dst;
    rq.src   = src;
    rq.port  = port;
    rq.typed = typed;
    rq.want  = '{st, fport, fdst, fsrc};
    return rq;
  endfunction

  task automatic report_mismatch(string msg);
    if (errors < 50) $display("mismatch: %s", msg);
    errors++;
  endtask

  // Wait for the next falling edge, then occasionally add an idle burst.
  task automatic wait_turn();
    @(negedge clk);
    if (stall_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
  endtask

  task automatic send_item(flow_req_t rq);
    in_valid    <= 1'b1;
    req_type    <= rq.req;
    switch_id   <= rq.sw;
    dst_mac     <= rq.dst;
    src_mac     <= rq.src;
    egress_port <= rq.port;
    cur_typed   <= rq.typed;
    cur_want    <= rq.want;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic run_phase(traffic_mode_t mode, int items);
    flow_req_t rq;
    int pick;
    int slot;
    bit copy_key;
    repeat (items) begin
      wait_turn();
      pick = $urandom_range(0, 99);
      copy_key = 1'b0;
      rq.typed = 1'b0;
      rq.want  = '0;
      if ($urandom_range(0, 99) < (mode == MODE_FILL ? 80 : 25)) begin
        rq.sw   = SW_W'($urandom_range(0, 255));
        rq.dst  = rand_mac();
        rq.src  = rand_mac();
        rq.port = PORT_W'($urandom_range(0, 65535));
      end else begin
        rq.sw   = SW_W'($urandom_range(0, 3));
        rq.dst  = MAC_W'($urandom_range(0, 7));
        rq.src  = MAC_W'($urandom_range(0, 7));
        rq.port = PORT_W'($urandom_range(0, 7));
      end
      case (mode)
        MODE_MIX: begin
          if (pick < 40) begin
            rq.req = REQ_INSERT;
            copy_key = pick < 8;
          end else if (pick < 70) begin
            rq.req = REQ_LOOKUP;
            copy_key = pick < 58;
          end else if (pick < 95) begin
            rq.req = REQ_REMOVE;
            copy_key = pick < 88;
          end else begin
            rq.req  = REQ_UNUSED;
            rq.sw   = SW_W'($urandom_range(0, 255));
            rq.dst  = rand_mac();
            rq.src  = rand_mac();
            rq.port = PORT_W'($urandom_range(0, 65535));
          end
        end
        MODE_FILL: begin
          rq.req = pick < 85 ? REQ_INSERT : REQ_LOOKUP;
          copy_key = pick >= 85;
        end
        default: begin
          rq.req = pick < 85 ? REQ_REMOVE : REQ_LOOKUP;
          copy_key = pick < 70 || pick >= 85;
        end
      endcase
      slot = flow_count > 0 ? $urandom_range(0, flow_count - 1) : -1;
      if (copy_key && slot >= 0) begin
        rq.sw  = flow_tbl[slot].sw;
        rq.dst = flow_tbl[slot].dst;
        rq.src = flow_tbl[slot].src;
        if (rq.req == REQ_REMOVE) rq.port = flow_tbl[slot].port;
      end
      send_item(rq);
    end
    drain_results();
  endtask

  // Randomly hold off the result channel.
  initial begin
    out_ready = 1'b1;
    forever begin
      @(negedge clk);
      if (stall_on && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(negedge clk);
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        seen_req.req  = req_type;
        seen_req.sw   = switch_id;
        seen_req.dst  = dst_mac;
        seen_req.src  = src_mac;
        seen_req.port = egress_port;
        predicted = apply_request(seen_req);
        if (flow_count > peak_count) peak_count = flow_count;
        n_req[req_type]++;
        n_status[predicted.status]++;
        pending_results.push_back(cur_typed ? cur_want : predicted);
      end
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with no request outstanding",
                                    n_results));
        end else begin
          oldest = pending_results.pop_front();
          if (status !== oldest.status)
            report_mismatch($sformatf("result %0d status %0d, want %0d",
                                      n_results, status, oldest.status));
          if (found_port !== oldest.port)
            report_mismatch($sformatf("result %0d found_port %h, want %h",
                                      n_results, found_port, oldest.port));
          if (found_dst_mac !== oldest.dst)
            report_mismatch($sformatf("result %0d found_dst_mac %h, want %h",
                                      n_results, found_dst_mac, oldest.dst));
          if (found_src_mac !== oldest.src)
            report_mismatch($sformatf("result %0d found_src_mac %h, want %h",
                                      n_results, found_src_mac, oldest.src));
        end
        n_results++;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    flow_req_t     plan [$];
    traffic_mode_t phase_mode [PHASES];
    int            phase_len [PHASES];
    int            k;

    rst         = 1'b1;
    in_valid    = 1'b0;
    req_type    = '0;
    switch_id   = '0;
    dst_mac     = '0;
    src_mac     = '0;
    egress_port = '0;
    cur_typed   = 1'b0;
    cur_want    = '0;
    stall_on    = 1'b1;
    flow_count  = 0;
    peak_count  = 0;
    errors      = 0;
    n_results   = 0;
    idle_cycles = 0;

    phase_mode = '{MODE_MIX, MODE_FILL, MODE_MIX, MODE_DRAIN,
                   MODE_FILL, MODE_MIX, MODE_DRAIN, MODE_MIX};
    phase_len  = '{350, 150, 250, 150, 150, 300, 120, 200};

    plan.push_back(stim_row(REQ_LOOKUP, 0, 0, 0, 0, 1, ST_NOT_FOUND, 0, 0, 0));
    plan.push_back(stim_row(REQ_REMOVE, 0, 0, 0, 0, 1, ST_NOT_FOUND, 0, 0, 0));
    plan.push_back(stim_row(REQ_UNUSED, 8'hFF, MAC_ONES, MAC_ONES, PORT_ONES, 1,
                            ST_NOT_FOUND, 0, 0, 0));
    plan.push_back(stim_row(REQ_INSERT, 0, 0, 0, 0, 1, ST_OK, 0, 0, 0));
    plan.push_back(stim_row(REQ_INSERT, 8'hFF, MAC_ONES, MAC_ONES, PORT_ONES, 1,
                            ST_OK, 0, 0, 0));
    plan.push_back(stim_row(REQ_INSERT, 8'hFF, MAC_ONES, MAC_ONES, 16'h1234, 1,
                            ST_PRESENT, 0, 0, 0));
    plan.push_back(stim_row(REQ_LOOKUP, 8'hFF, MAC_ONES, MAC_ONES, 0, 1,
                            ST_OK, PORT_ONES, MAC_ONES, MAC_ONES));
    plan.push_back(stim_row(REQ_LOOKUP, 0, 0, 0, PORT_ONES, 1, ST_OK, 0, 0, 0));
    plan.push_back(stim_row(REQ_LOOKUP, 8'hFF, 0, MAC_ONES, 0, 1, ST_NOT_FOUND, 0, 0, 0));
    plan.push_back(stim_row(REQ_INSERT, 7, 1, 2, 5, 1, ST_OK, 0, 0, 0));
    plan.push_back(stim_row(REQ_INSERT, 7, 3, 4, 5, 1, ST_OK, 0, 0, 0));
    plan.push_back(stim_row(REQ_INSERT, 8, 9, 9, 5, 1, ST_OK, 0, 0, 0));
    plan.push_back(stim_row(REQ_REMOVE, 7, 0, 0, 5, 1, ST_OK, 5, 3, 4));
    plan.push_back(stim_row(REQ_REMOVE, 7, 0, 0, 5, 1, ST_OK, 5, 1, 2));
    plan.push_back(stim_row(REQ_REMOVE, 7, 0, 0, 5, 1, ST_NOT_FOUND, 0, 0, 0));
    plan.push_back(stim_row(REQ_REMOVE, 8'hFF, 0, 0, PORT_ONES, 1,
                            ST_OK, PORT_ONES, MAC_ONES, MAC_ONES));
    plan.push_back(stim_row(REQ_LOOKUP, 8'hFF, MAC_ONES, MAC_ONES, 0, 1,
                            ST_NOT_FOUND, 0, 0, 0));
    plan.push_back(stim_row(REQ_REMOVE, 0, 0, 0, 0, 1, ST_OK, 0, 0, 0));
    plan.push_back(stim_row(REQ_LOOKUP, 8, 9, 9, 0, 1, ST_OK, 5, 9, 9));
    plan.push_back(stim_row(REQ_INSERT, 8'h5A, 48'h0123_4567_89AB, 48'hA5A5_5A5A_C3C3,
                            16'hBEEF, 0, ST_OK, 0, 0, 0));
    plan.push_back(stim_row(REQ_LOOKUP, 8'h5A, 48'h0123_4567_89AB, 48'hA5A5_5A5A_C3C3,
                            0, 0, ST_OK, 0, 0, 0));

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (plan[k]) begin
      wait_turn();
      send_item(plan[k]);
    end
    drain_results();

    for (k = 0; k < PHASES; k++) begin
      if (k == PHASES - 1) stall_on = 1'b0;
      run_phase(phase_mode[k], phase_len[k]);
    end

    repeat (12) @(posedge clk);

    $display("covered %0d inserts, %0d lookups, %0d removes, %0d unknown requests",
             n_req[REQ_INSERT], n_req[REQ_LOOKUP], n_req[REQ_REMOVE], n_req[REQ_UNUSED]);
    $display("outcomes: %0d ok, %0d not found, %0d already present, %0d table full; peak %0d/%0d",
             n_status[ST_OK], n_status[ST_NOT_FOUND], n_status[ST_PRESENT],
             n_status[ST_FULL], peak_count, TABLE_ENTRIES);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== flow_match_table_core.f =====
rtl/fmt_pkg.sv
rtl/fmt_cell.sv
rtl/flow_match_table_core.sv
sim/flow_match_table_tb.sv
